FILE: src/afc_pkg.sv
// Shared constants and types for the box frustum cull and coverage block.
package afc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF  = 16;
  localparam int COORD_FRAC      = 4;
  localparam int AXES            = 3;
  localparam int ROWS            = 4;
  localparam int CORNERS         = 8;
  localparam int PLANES          = 6;
  localparam int REG_W           = 64;
  localparam int VP_W            = 13;
  localparam int DIV_W           = 2 * VP_W;
  localparam int Q_W             = 32;
  localparam int Q_FRAC          = 16;
  localparam int CFG_IDX_W       = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_W  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_H   = 3'd5;

  // matrix rows: indexes into the row array
  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_Z = 2;
  localparam int ROW_W = 3;

  // reset values: identity matrix, 1024 x 768 viewport
  localparam logic [REG_W-1:0] RST_ROW_X = 64'h0000_0000_0000_1000;
  localparam logic [REG_W-1:0] RST_ROW_Y = 64'h0000_0000_1000_0000;
  localparam logic [REG_W-1:0] RST_ROW_Z = 64'h0000_1000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW_W = 64'h1000_0000_0000_0000;
  localparam logic [VP_W-1:0]  RST_VP_W  = 13'd1024;
  localparam logic [VP_W-1:0]  RST_VP_H  = 13'd768;

  // classification result handed to the coverage pipe
  typedef struct packed {
    logic              valid;
    logic [PLANES-1:0] mask;
  } cls_t;

endpackage

FILE: src/afc_transform.sv
// Two-stage corner transform: per-axis products, then corner sums per matrix row.
module afc_transform #(
  parameter int COORD_W = afc_pkg::COORD_WIDTH_DEF,
  parameter int COEF_W  = afc_pkg::COEF_WIDTH_DEF,
  parameter int PW      = COORD_W + COEF_W,
  parameter int CLIP_W  = (PW + 2 > 64) ? 64 : PW + 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 valid_i,
  input  logic [afc_pkg::AXES*COORD_W-1:0]     lo_i,
  input  logic [afc_pkg::AXES*COORD_W-1:0]     hi_i,
  input  logic [afc_pkg::REG_W-1:0]            row_i [afc_pkg::ROWS],
  output logic                                 valid_o,
  output logic signed [CLIP_W-1:0]             clip_o [afc_pkg::CORNERS][afc_pkg::ROWS]
);

  localparam int LW = afc_pkg::ROWS * COEF_W;

  logic signed [COEF_W-1:0]  lane [afc_pkg::ROWS][afc_pkg::ROWS];
  logic signed [PW-1:0]      prod_nxt [afc_pkg::ROWS][afc_pkg::AXES][2];
  logic signed [PW-1:0]      prod_r   [afc_pkg::ROWS][afc_pkg::AXES][2];
  logic signed [CLIP_W-1:0]  trans_nxt [afc_pkg::ROWS];
  logic signed [CLIP_W-1:0]  trans_r   [afc_pkg::ROWS];
  logic signed [CLIP_W-1:0]  clip_nxt [afc_pkg::CORNERS][afc_pkg::ROWS];
  logic signed [CLIP_W-1:0]  clip_r   [afc_pkg::CORNERS][afc_pkg::ROWS];
  logic                      va_r, vb_r;

  // coefficient lanes; bits past the 64-bit register read as zero
  always_comb begin
    logic [LW-1:0] rowx;
    for (int r = 0; r < afc_pkg::ROWS; r++) begin
      rowx = LW'(row_i[r]);
      for (int l = 0; l < afc_pkg::ROWS; l++) begin
        lane[r][l] = $signed(rowx[l*COEF_W +: COEF_W]);
      end
    end
  end

  // stage A: one product per row, axis and min/max choice
  always_comb begin
    logic signed [COORD_W-1:0] cl, ch;
    for (int r = 0; r < afc_pkg::ROWS; r++) begin
      for (int a = 0; a < afc_pkg::AXES; a++) begin
        cl = $signed(lo_i[a*COORD_W +: COORD_W]);
        ch = $signed(hi_i[a*COORD_W +: COORD_W]);
        prod_nxt[r][a][0] = PW'(lane[r][a]) * PW'(cl);
        prod_nxt[r][a][1] = PW'(lane[r][a]) * PW'(ch);
      end
      trans_nxt[r] = CLIP_W'(lane[r][3]) <<< afc_pkg::COORD_FRAC;
    end
  end

  // stage B: corner c takes max on axis k when bit k of c is set
  always_comb begin
    for (int c = 0; c < afc_pkg::CORNERS; c++) begin
      for (int r = 0; r < afc_pkg::ROWS; r++) begin
        clip_nxt[c][r] = CLIP_W'(prod_r[r][0][1'(c)])
                       + CLIP_W'(prod_r[r][1][1'(c >> 1)])
                       + CLIP_W'(prod_r[r][2][1'(c >> 2)])
                       + trans_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      trans_r <= trans_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign valid_o = vb_r;
  assign clip_o  = clip_r;

endmodule

FILE: src/afc_classify.sv
// Plane tests over the eight corners and x/y extents of the clip values.
module afc_classify #(
  parameter int CLIP_W = 34,
  parameter int EW     = (CLIP_W < 64) ? CLIP_W + 1 : 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     valid_i,
  input  logic signed [CLIP_W-1:0] clip_i [afc_pkg::CORNERS][afc_pkg::ROWS],
  output afc_pkg::cls_t            cls_o,
  output logic [EW-1:0]            ex_o,
  output logic [EW-1:0]            ey_o
);

  localparam int XW = CLIP_W + 1;

  afc_pkg::cls_t       cls_r;
  logic [afc_pkg::PLANES-1:0] mask_nxt;
  logic [EW-1:0]       ex_nxt, ey_nxt, ex_r, ey_r;

  // compares run one bit wider so that -w never overflows
  always_comb begin
    logic signed [XW-1:0] cx, cy, cz, cw, nw;
    logic signed [XW-1:0] xmin, xmax, ymin, ymax;
    logic signed [XW-1:0] dx, dy;
    mask_nxt = '1;
    xmin = '0; xmax = '0; ymin = '0; ymax = '0;
    for (int c = 0; c < afc_pkg::CORNERS; c++) begin
      cx = XW'(clip_i[c][afc_pkg::ROW_X]);
      cy = XW'(clip_i[c][afc_pkg::ROW_Y]);
      cz = XW'(clip_i[c][afc_pkg::ROW_Z]);
      cw = XW'(clip_i[c][afc_pkg::ROW_W]);
      nw = -cw;
      mask_nxt[0] &= (cx < nw);
      mask_nxt[1] &= (cy < nw);
      mask_nxt[2] &= (cz < nw);
      mask_nxt[3] &= (cx > cw);
      mask_nxt[4] &= (cy > cw);
      mask_nxt[5] &= (cz > cw);
      if (c == 0 || cx < xmin) xmin = cx;
      if (c == 0 || cx > xmax) xmax = cx;
      if (c == 0 || cy < ymin) ymin = cy;
      if (c == 0 || cy > ymax) ymax = cy;
    end
    dx = xmax - xmin;
    dy = ymax - ymin;
    ex_nxt = EW'(dx);
    ey_nxt = EW'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r.valid <= 1'b0;
    end else if (en) begin
      cls_r.valid <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r.mask <= mask_nxt;
      ex_r       <= ex_nxt;
      ey_r       <= ey_nxt;
    end
  end

  assign cls_o = cls_r;
  assign ex_o  = ex_r;
  assign ey_o  = ey_r;

endmodule

FILE: src/afc_coverage.sv
// Extent product and pipelined restoring division giving saturated Q16.16 coverage.
module afc_coverage #(
  parameter int EW = 35
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  afc_pkg::cls_t               cls_i,
  input  logic [EW-1:0]               ex_i,
  input  logic [EW-1:0]               ey_i,
  input  logic [afc_pkg::DIV_W-1:0]   div_i,
  output logic                        valid_o,
  output logic [afc_pkg::PLANES-1:0]  mask_o,
  output logic [afc_pkg::Q_W-1:0]     cov_o
);

  localparam int HW  = (EW + 1) / 2;
  localparam int UW  = EW - HW;
  localparam int NW  = 2 * EW;
  localparam int NX  = (NW > afc_pkg::Q_W + afc_pkg::Q_FRAC + afc_pkg::DIV_W) ?
                       NW : afc_pkg::Q_W + afc_pkg::Q_FRAC + afc_pkg::DIV_W;
  localparam int DW  = afc_pkg::DIV_W;
  localparam int QW  = afc_pkg::Q_W;
  localparam int QF  = afc_pkg::Q_FRAC;

  // multiply stage: extent x split in two halves
  logic [HW+EW-1:0] plo_r;
  logic [UW+EW-1:0] phi_r;
  afc_pkg::cls_t    m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r.valid <= 1'b0;
    end else if (en) begin
      m_r.valid <= cls_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r.mask <= cls_i.mask;
      plo_r    <= (HW+EW)'(ex_i[HW-1:0]) * (HW+EW)'(ey_i);
      phi_r    <= (UW+EW)'(ex_i[EW-1:HW]) * (UW+EW)'(ey_i);
    end
  end

  // division stages; index 0 holds the recombined product
  logic [DW-1:0] rem_r  [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic [QW-1:0] nlo_r  [QW+1];
  logic          sat_r  [QW+1];
  logic          v_r    [QW+1];
  logic [afc_pkg::PLANES-1:0] mask_r [QW+1];

  logic [NX-1:0] prod_x;
  logic          sat_nxt;

  // dividend is product >> 16; quotient overflows 32 bits when product >> 48
  // reaches the divisor
  always_comb begin
    logic [NW-1:0] prod;
    prod    = (NW'(phi_r) << HW) + NW'(plo_r);
    prod_x  = NX'(prod);
    sat_nxt = prod_x[NX-1:QW+QF] >= (NX-QW-QF)'(div_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= m_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= prod_x[QW+QF+DW-1:QW+QF];
      q_r[0]    <= '0;
      nlo_r[0]  <= prod_x[QW+QF-1:QF];
      sat_r[0]  <= sat_nxt;
      mask_r[0] <= m_r.mask;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[s], nlo_r[s][QW-1]};
      ge      = trial >= {1'b0, div_i};
      rem_nxt = ge ? DW'(trial - {1'b0, div_i}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= rem_nxt;
        q_r[s+1]    <= {q_r[s][QW-2:0], ge};
        nlo_r[s+1]  <= nlo_r[s] << 1;
        sat_r[s+1]  <= sat_r[s];
        mask_r[s+1] <= mask_r[s];
      end
    end
  end

  assign valid_o = v_r[QW];
  assign mask_o  = mask_r[QW];
  always_comb begin
    if (mask_r[QW] != '0) cov_o = '0;
    else if (sat_r[QW])   cov_o = '1;
    else                  cov_o = q_r[QW];
  end

endmodule

FILE: src/aabb_frustum_cull_coverage.sv
// Top level: box frustum cull and screen coverage, one box per cycle unless stalled.
//
// Input stream (in_*): one request per box, six signed coordinates packed in
// in_tdata, min x/y/z then max x/y/z. Output stream (out_*): one request per
// box in the same order with visibility, the six-plane outside mask and the
// Q16.16 coverage (0 for a culled box).
// Configuration (cfg_*): matrix rows 0..3 and viewport width/height 4..5;
// other indexes are ignored. Write them only while no box is in flight; the
// block itself does not enforce it. From input accept to output valid a box
// passes two transform stages, one classify stage, one multiply stage, one
// product stage and one stage per quotient bit of the 32-bit divider, which
// makes up most of the pipeline. Throughput is one box per cycle unless the
// receiver stalls; then the whole pipeline holds, in_tready drops in the
// same cycle, and nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity
// matrix and a 1024 x 768 viewport.
module aabb_frustum_cull_coverage #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = afc_pkg::COEF_WIDTH_DEF,
  parameter int IN_DW       = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [IN_DW-1:0]                in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // visible, outside_plane_mask[5:0], screen_coverage[31:0], zero pad
  output logic [39:0]                     out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [afc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [afc_pkg::REG_W-1:0]       cfg_wdata
);

  localparam int PW     = COORD_WIDTH + COEF_WIDTH;
  localparam int CLIP_W = (PW + 2 > 64) ? 64 : PW + 2;
  localparam int EW     = (CLIP_W < 64) ? CLIP_W + 1 : 64;
  localparam int AW     = afc_pkg::AXES * COORD_WIDTH;

  logic [afc_pkg::REG_W-1:0]  row_r [afc_pkg::ROWS];
  logic [afc_pkg::VP_W-1:0]   vpw_r, vph_r;
  logic [afc_pkg::DIV_W-1:0]  div_r;
  logic                       en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[afc_pkg::ROW_X] <= afc_pkg::RST_ROW_X;
      row_r[afc_pkg::ROW_Y] <= afc_pkg::RST_ROW_Y;
      row_r[afc_pkg::ROW_Z] <= afc_pkg::RST_ROW_Z;
      row_r[afc_pkg::ROW_W] <= afc_pkg::RST_ROW_W;
      vpw_r <= afc_pkg::RST_VP_W;
      vph_r <= afc_pkg::RST_VP_H;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        afc_pkg::CFG_ROW_X: row_r[afc_pkg::ROW_X] <= cfg_wdata;
        afc_pkg::CFG_ROW_Y: row_r[afc_pkg::ROW_Y] <= cfg_wdata;
        afc_pkg::CFG_ROW_Z: row_r[afc_pkg::ROW_Z] <= cfg_wdata;
        afc_pkg::CFG_ROW_W: row_r[afc_pkg::ROW_W] <= cfg_wdata;
        afc_pkg::CFG_VP_W:  vpw_r <= cfg_wdata[afc_pkg::VP_W-1:0];
        afc_pkg::CFG_VP_H:  vph_r <= cfg_wdata[afc_pkg::VP_W-1:0];
        default: ;
      endcase
    end
  end

  // viewport area; zero sizes count as one
  always_ff @(posedge clk) begin
    logic [afc_pkg::VP_W-1:0] w, h;
    w = (vpw_r == '0) ? afc_pkg::VP_W'(1) : vpw_r;
    h = (vph_r == '0) ? afc_pkg::VP_W'(1) : vph_r;
    div_r <= afc_pkg::DIV_W'(w) * afc_pkg::DIV_W'(h);
  end

  // whole pipe advances unless a result is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic                      t_valid;
  logic signed [CLIP_W-1:0]  clip [afc_pkg::CORNERS][afc_pkg::ROWS];
  afc_pkg::cls_t             cls;
  logic [EW-1:0]             ex, ey;
  logic [afc_pkg::PLANES-1:0] mask;
  logic [afc_pkg::Q_W-1:0]   cov;

  afc_transform #(
    .COORD_W (COORD_WIDTH),
    .COEF_W  (COEF_WIDTH)
  ) u_transform (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_tvalid),
    .lo_i    (in_tdata[AW-1:0]),
    .hi_i    (in_tdata[2*AW-1:AW]),
    .row_i   (row_r),
    .valid_o (t_valid),
    .clip_o  (clip)
  );

  afc_classify #(
    .CLIP_W (CLIP_W)
  ) u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (t_valid),
    .clip_i  (clip),
    .cls_o   (cls),
    .ex_o    (ex),
    .ey_o    (ey)
  );

  afc_coverage #(
    .EW (EW)
  ) u_coverage (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cls_i   (cls),
    .ex_i    (ex),
    .ey_i    (ey),
    .div_i   (div_r),
    .valid_o (out_tvalid),
    .mask_o  (mask),
    .cov_o   (cov)
  );

  assign out_tdata = {1'b0, cov, mask, (mask == '0)};

`ifndef SYNTHESIS
  // pipe is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a culled box never reports coverage
  a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:1] != 6'd0 |-> out_tdata[38:7] == 32'd0)
    else $error("culled box with coverage");

  // a held result stays put while the pipe is stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held result changed");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the box frustum cull and screen coverage block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // box fields, last field in the lowest bits, so the struct packs as in_tdata
  typedef struct packed {
    shortint max_z;
    shortint max_y;
    shortint max_x;
    shortint min_z;
    shortint min_y;
    shortint min_x;
  } box_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [95:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;
  logic              cfg_wr_en = 1'b0;
  logic [afc_pkg::CFG_IDX_W-1:0] cfg_addr = afc_pkg::CFG_ROW_X;
  logic [afc_pkg::REG_W-1:0]  cfg_wdata = '0;

  // shadow of the block's registers
  logic [afc_pkg::REG_W-1:0]  mat_q [afc_pkg::ROWS];
  logic [afc_pkg::VP_W-1:0]   vp_w_q = afc_pkg::RST_VP_W;
  logic [afc_pkg::VP_W-1:0]   vp_h_q = afc_pkg::RST_VP_H;

  box_t              box_q [$];
  logic [39:0]       cull_exp_q [$];
  int                idle_pct = 24;
  int                stall_tok = 0;
  int                n_err = 0;
  int                n_boxes = 0;
  int                n_visible = 0;
  int                n_culled = 0;
  int                n_sat = 0;

  always #4 clk = ~clk;

  aabb_frustum_cull_coverage i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    mat_q[afc_pkg::ROW_X] = afc_pkg::RST_ROW_X;
    mat_q[afc_pkg::ROW_Y] = afc_pkg::RST_ROW_Y;
    mat_q[afc_pkg::ROW_Z] = afc_pkg::RST_ROW_Z;
    mat_q[afc_pkg::ROW_W] = afc_pkg::RST_ROW_W;
  end

  // expected {pad, coverage, mask, visible} for one box
  function automatic logic [39:0] cull_predict(box_t b);
    longint lo [afc_pkg::AXES];
    longint hi [afc_pkg::AXES];
    longint clip [afc_pkg::ROWS];
    longint px, py, pz, xmin, xmax, ymin, ymax;
    int cnt [afc_pkg::PLANES];
    logic [afc_pkg::PLANES-1:0] mask;
    logic [127:0] prod, den, q;
    logic [63:0] ex, ey;
    logic [31:0] cov;
    logic [afc_pkg::VP_W-1:0] vw, vh;
    lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
    hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
    foreach (cnt[p]) cnt[p] = 0;
    xmin = 0; xmax = 0; ymin = 0; ymax = 0;
    for (int c = 0; c < afc_pkg::CORNERS; c++) begin
      px = c[0] ? hi[0] : lo[0];
      py = c[1] ? hi[1] : lo[1];
      pz = c[2] ? hi[2] : lo[2];
      for (int r = 0; r < afc_pkg::ROWS; r++)
        clip[r] = longint'($signed(mat_q[r][15:0])) * px
                + longint'($signed(mat_q[r][31:16])) * py
                + longint'($signed(mat_q[r][47:32])) * pz
                + longint'($signed(mat_q[r][63:48])) * 16;
      for (int a = 0; a < afc_pkg::AXES; a++) begin
        // most negative w counts as outside the low plane
        if (clip[afc_pkg::ROW_W] == 64'sh8000_0000_0000_0000
            || clip[a] < -clip[afc_pkg::ROW_W])
          cnt[a]++;
        if (clip[a] > clip[afc_pkg::ROW_W]) cnt[a + 3]++;
      end
      if (c == 0 || clip[afc_pkg::ROW_X] < xmin) xmin = clip[afc_pkg::ROW_X];
      if (c == 0 || clip[afc_pkg::ROW_X] > xmax) xmax = clip[afc_pkg::ROW_X];
      if (c == 0 || clip[afc_pkg::ROW_Y] < ymin) ymin = clip[afc_pkg::ROW_Y];
      if (c == 0 || clip[afc_pkg::ROW_Y] > ymax) ymax = clip[afc_pkg::ROW_Y];
    end
    foreach (cnt[p]) mask[p] = (cnt[p] == afc_pkg::CORNERS);
    cov = '0;
    if (mask == '0) begin
      ex = xmax - xmin;
      ey = ymax - ymin;
      vw = (vp_w_q == '0) ? 13'd1 : vp_w_q;
      vh = (vp_h_q == '0) ? 13'd1 : vp_h_q;
      prod = {64'd0, ex} * {64'd0, ey};
      den = ({115'd0, vw} * {115'd0, vh}) << afc_pkg::Q_FRAC;
      q = prod / den;
      cov = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    return {1'b0, cov, mask, (mask == '0)};
  endfunction

  // sender: offers queued boxes, records each accepted one
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cull_exp_q.push_back(cull_predict(box_t'(in_tdata)));
      n_boxes++;
    end
    if (!in_tvalid || in_tready) begin
      if (rst_n && box_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= box_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus a long hold-off on request
  int seen_tok = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (stall_tok != seen_tok) begin
      seen_tok  <= stall_tok;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [39:0] want;
    if (out_tvalid && out_tready) begin
      if (cull_exp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = cull_exp_q.pop_front();
        if (want[0] !== out_tdata[0] || want[6:1] !== out_tdata[6:1]
            || want[38:7] !== out_tdata[38:7]) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: vis %b/%b mask %b/%b cov %h/%h (exp/got)",
                     want[0], out_tdata[0], want[6:1], out_tdata[6:1],
                     want[38:7], out_tdata[38:7]);
        end
        if (want[0]) n_visible++; else n_culled++;
        if (want[38:7] == 32'hFFFF_FFFF) n_sat++;
      end
    end
  end

  task automatic cfg_write(logic [afc_pkg::CFG_IDX_W-1:0] idx,
                           logic [afc_pkg::REG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      afc_pkg::CFG_ROW_X: mat_q[afc_pkg::ROW_X] = val;
      afc_pkg::CFG_ROW_Y: mat_q[afc_pkg::ROW_Y] = val;
      afc_pkg::CFG_ROW_Z: mat_q[afc_pkg::ROW_Z] = val;
      afc_pkg::CFG_ROW_W: mat_q[afc_pkg::ROW_W] = val;
      afc_pkg::CFG_VP_W:  vp_w_q = val[afc_pkg::VP_W-1:0];
      afc_pkg::CFG_VP_H:  vp_h_q = val[afc_pkg::VP_W-1:0];
      default: ;
    endcase
  endtask

  // wait for the pipe to empty, then the full latency again
  task automatic drain();
    while (box_q.size() > 0 || in_tvalid || cull_exp_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send(box_t b);
    @(negedge clk);
    box_q.push_back(b);
  endtask

  function automatic shortint rand_coord();
    case ($urandom_range(0, 3))
      0, 1: return shortint'($urandom_range(0, 96)) - 16'sd48;
      2: return shortint'($urandom_range(0, 2048)) - 16'sd1024;
      default: return shortint'($urandom);
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    b.min_x = rand_coord(); b.min_y = rand_coord(); b.min_z = rand_coord();
    if ($urandom_range(0, 3) == 0) begin
      b.max_x = rand_coord(); b.max_y = rand_coord(); b.max_z = rand_coord();
    end else begin
      b.max_x = b.min_x + shortint'($urandom_range(0, 40));
      b.max_y = b.min_y + shortint'($urandom_range(0, 40));
      b.max_z = b.min_z + shortint'($urandom_range(0, 40));
    end
    return b;
  endfunction

  function automatic logic [afc_pkg::REG_W-1:0] rand_row();
    logic [afc_pkg::REG_W-1:0] r;
    for (int i = 0; i < afc_pkg::ROWS; i++)
      r[i*16 +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                      : 16'($urandom_range(0, 16'h2000) - 16'h1000);
    return r;
  endfunction

  task automatic rand_burst(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        @(negedge clk);
        stall_tok = stall_tok + 1;
      end
      send(rand_box());
    end
  endtask

  // stimulus and phases
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // identity matrix: inside, edges, each plane culled, swapped corners
    send('{16'sd8, 16'sd8, 16'sd8, -16'sd8, -16'sd8, -16'sd8});
    send('0);
    send('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000});
    send('{-16'sd8, -16'sd8, -16'sd8, 16'sd8, 16'sd8, 16'sd8});
    send('{16'sd16, 16'sd16, 16'sd16, -16'sd16, -16'sd16, -16'sd16});
    send('{16'sd5, 16'sd5, -16'sd17, -16'sd5, -16'sd5, -16'sd40});
    send('{16'sd5, -16'sd17, 16'sd5, -16'sd5, -16'sd40, -16'sd5});
    send('{-16'sd17, 16'sd5, 16'sd5, -16'sd40, -16'sd5, -16'sd5});
    send('{16'sd40, 16'sd5, 16'sd5, 16'sd17, -16'sd5, -16'sd5});
    send('{16'sd5, 16'sd40, 16'sd5, -16'sd5, 16'sd17, -16'sd5});
    send('{16'sd5, 16'sd5, 16'sd40, -16'sd5, -16'sd5, 16'sd17});
    send('{-16'sh8000, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    drain();

    // phase 1: default registers, sender idles randomly
    rand_burst(400);
    drain();

    // phase 2: random matrix and viewport, no random idling on either side
    cfg_write(afc_pkg::CFG_ROW_X, rand_row());
    cfg_write(afc_pkg::CFG_ROW_Y, rand_row());
    cfg_write(afc_pkg::CFG_ROW_Z, rand_row());
    cfg_write(afc_pkg::CFG_ROW_W, rand_row() | 64'h4000_0000_0000_0000);
    cfg_write(afc_pkg::CFG_VP_W, 64'($urandom_range(1, 4096)));
    cfg_write(afc_pkg::CFG_VP_H, 64'($urandom_range(1, 4096)));
    cfg_write(3'd6, '1);
    cfg_write(3'd7, '1);
    @(negedge clk);
    idle_pct = 0;
    rand_burst(400);
    drain();
    @(negedge clk);
    idle_pct = 24;

    // phase 3: extreme coefficients, zero viewport, saturation
    cfg_write(afc_pkg::CFG_ROW_X, 64'h8000_7FFF_8000_7FFF);
    cfg_write(afc_pkg::CFG_ROW_Y, 64'h7FFF_8000_7FFF_8000);
    cfg_write(afc_pkg::CFG_ROW_Z, '0);
    cfg_write(afc_pkg::CFG_ROW_W, 64'h7FFF_0000_0000_0000);
    cfg_write(afc_pkg::CFG_VP_W, '0);
    cfg_write(afc_pkg::CFG_VP_H, 64'h1FFF);
    send('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000});
    send('0);
    rand_burst(400);
    drain();
    cfg_write(afc_pkg::CFG_VP_H, '0);
    send('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000});
    rand_burst(100);
    drain();

    // phase 4: perspective-like matrix, 4096 x 1 viewport
    cfg_write(afc_pkg::CFG_ROW_X, 64'h0000_0000_0000_2000);
    cfg_write(afc_pkg::CFG_ROW_Y, 64'h0000_0000_2000_0000);
    cfg_write(afc_pkg::CFG_ROW_Z, 64'hF000_F000_0000_0000);
    cfg_write(afc_pkg::CFG_ROW_W, 64'h0000_F000_0000_0000);
    cfg_write(afc_pkg::CFG_VP_W, 64'd4096);
    cfg_write(afc_pkg::CFG_VP_H, 64'd1);
    rand_burst(400);
    drain();

    $display("Checked %0d boxes over four register settings: %0d visible, %0d culled,",
             n_boxes, n_visible, n_culled);
    $display("%0d saturated coverage values, %0d mismatches.", n_sat, n_err);
    if (n_err == 0 && cull_exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: aabb_frustum_cull_coverage.f
src/afc_pkg.sv
src/afc_transform.sv
src/afc_classify.sv
src/afc_coverage.sv
src/aabb_frustum_cull_coverage.sv
test/tb.sv
